// ===== rtl/tlhem_pkg.sv =====
package tlhem_pkg;

  localparam int CW = 20;
  localparam int FW = 31;

  typedef struct packed {
    logic [CW-1:0] count_00;
    logic [CW-1:0] count_01;
    logic [CW-1:0] count_02;
    logic [CW-1:0] count_10;
    logic [CW-1:0] count_11;
    logic [CW-1:0] count_12;
    logic [CW-1:0] count_20;
    logic [CW-1:0] count_21;
    logic [CW-1:0] count_22;
  } tlhem_in_t;

  typedef struct packed {
    logic [31:0] freq_01;
    logic [31:0] freq_10;
    logic [31:0] freq_11;
    logic [1:0]  status;
    logic [7:0]  rounds_used;
  } tlhem_out_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIV  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_ITER  = 2'd0,
    REG_TOLERANCE = 2'd1
  } reg_index_t;

  // operand widths
  localparam int NW = 128;
  localparam int PW = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_EST, S_EST_WAIT, S_PROD, S_PROD_WAIT, S_SPLIT,
    S_SPLIT_WAIT, S_SQ, S_SQ_WAIT, S_CHECK, S_DONE
  } fsm_t;

endpackage

// ===== rtl/two_locus_haplotype_em.sv =====
// Two-locus haplotype EM estimator.
// Input: pulse start with a 3x3 genotype count table on item_in while busy
// is low; the word is captured at that edge and busy rises.
// Output: result_valid is high for one cycle with item_out (three Q1.31
// frequencies, status, rounds used); the receiver cannot stall it.
// Config: cfg_valid/cfg_ready write cfg_index/cfg_data; ready is high while
// idle and start is low. Index 0 sets the round limit, index 1 the tolerance.
// Schedule: all arithmetic runs on one bit-serial multiplier and one
// bit-serial divider. An estimate is a product, then a quotient. Setup
// is followed by three estimates and a check. Each EM round takes two
// products, a split quotient, three estimates, three squared differences
// and a check. The strobe follows the check that ends the run; an empty
// table gives it straight after setup, a zero split divisor right after
// the second product. busy drops the cycle after the strobe, so one item
// is in work at a time.
// Reset: control returns to idle, registers take limit 100, tolerance 429.
module two_locus_haplotype_em (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  tlhem_pkg::tlhem_in_t    item_in,
  output logic                    result_valid,
  output tlhem_pkg::tlhem_out_t   item_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data
);
  import tlhem_pkg::*;

  logic [7:0]  max_iter;
  logic [15:0] tol;
  fsm_t state, state_next;

  logic [CW+1:0] b01, b10, b11;
  logic [CW-1:0] g11;
  logic [CW+3:0] total;
  logic [63:0]   pi0, pi1, pi2, s, old0, old1, old2;
  logic [127:0]  prod_a, acc;
  logic [1:0]    sub;
  logic [7:0]    rounds;
  logic [7:0]    limit;
  logic [1:0]    status;

  logic          mgo, mdone, dgo, ddone;
  logic [63:0]   ma, mb, dq;
  logic [127:0]  mp, dn, dd;

  localparam logic [63:0] ONE = 64'd1 << FW;

  tlhem_mul u_mul (.clk, .rst, .go(mgo), .a(ma), .b(mb), .done(mdone), .p(mp));
  tlhem_div u_div (.clk, .rst, .go(dgo), .n(dn), .d(dd), .done(ddone), .q(dq));

  logic [63:0] used, p00, other, diff;
  logic        converged;
  assign used  = pi0 + pi1 + pi2;
  assign p00   = (used > ONE) ? 64'd0 : ONE - used;
  assign other = (s > ONE) ? 64'd0 : ONE - s;
  assign limit = (max_iter == 8'd0) ? 8'd1 : max_iter;
  assign converged = (rounds != 8'd0) && (acc <= (128'(tol) << (2*FW-32)));

  logic [63:0] cur_b, cur_old, cur_new;
  always_comb begin
    case (sub)
      2'd0: begin cur_b = 64'(b01); cur_old = old0; cur_new = pi0; end
      2'd1: begin cur_b = 64'(b10); cur_old = old1; cur_new = pi1; end
      default: begin cur_b = 64'(b11); cur_old = old2; cur_new = pi2; end
    endcase
  end
  assign diff = (cur_new > cur_old) ? cur_new - cur_old : cur_old - cur_new;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (start) state_next = S_SETUP;
      S_SETUP:      state_next = (total == '0) ? S_DONE : S_EST;
      S_EST:        state_next = S_EST_WAIT;
      S_EST_WAIT:   if (ddone && sub == 2'd2) state_next = (rounds != 8'd0) ? S_SQ : S_CHECK;
                    else if (ddone) state_next = S_EST;
      S_SQ:         state_next = S_SQ_WAIT;
      S_SQ_WAIT:    if (mdone && sub == 2'd2) state_next = S_CHECK;
                    else if (mdone) state_next = S_SQ;
      S_CHECK:      state_next = S_PROD;
      S_PROD:       state_next = S_PROD_WAIT;
      S_PROD_WAIT:  if (mdone && sub == 2'd1) state_next = S_SPLIT;
                    else if (mdone) state_next = S_PROD;
      S_SPLIT:      state_next = S_SPLIT_WAIT;
      S_SPLIT_WAIT: if (ddone) state_next = S_EST;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
    // early exits, decided here from datapath values
    if (state == S_CHECK && (converged || rounds == limit)) state_next = S_DONE;
    if (state == S_PROD_WAIT && mdone && sub == 2'd1 && (prod_a + mp) == '0)
      state_next = S_DONE;
  end

  always_comb begin
    busy = (state != S_IDLE);
    cfg_ready = (state == S_IDLE) && !start;
    result_valid = (state == S_DONE);
    item_out.freq_01 = pi0[31:0];
    item_out.freq_10 = pi1[31:0];
    item_out.freq_11 = pi2[31:0];
    item_out.status = status;
    item_out.rounds_used = rounds;
  end

  // estimate sub-step: multiply count_11 by share, then divide numerator
  logic est_mul;  // within S_EST_WAIT: multiply phase active

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_iter <= 8'd100;
      tol <= 16'd429;
      mgo <= 1'b0;
      dgo <= 1'b0;
      sub <= '0;
      est_mul <= 1'b0;
    end else begin
      state <= state_next;
      mgo <= 1'b0;
      dgo <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_ITER) max_iter <= cfg_data[7:0];
        else if (cfg_index == REG_TOLERANCE) tol <= cfg_data;
      end
      case (state)
        S_IDLE: if (start) begin
          g11 <= item_in.count_11;
          b01 <= (CW+2)'(item_in.count_01) + (CW+2)'({item_in.count_02, 1'b0})
               + (CW+2)'(item_in.count_12);
          b10 <= (CW+2)'(item_in.count_21) + (CW+2)'({item_in.count_20, 1'b0})
               + (CW+2)'(item_in.count_10);
          b11 <= (CW+2)'(item_in.count_21) + (CW+2)'({item_in.count_22, 1'b0})
               + (CW+2)'(item_in.count_12);
          total <= (CW+4)'(item_in.count_00) + (CW+4)'(item_in.count_01)
                 + (CW+4)'(item_in.count_02) + (CW+4)'(item_in.count_10)
                 + (CW+4)'(item_in.count_11) + (CW+4)'(item_in.count_12)
                 + (CW+4)'(item_in.count_20) + (CW+4)'(item_in.count_21)
                 + (CW+4)'(item_in.count_22);
          s <= ONE >> 1;
          rounds <= '0;
          pi0 <= '0; pi1 <= '0; pi2 <= '0;
          status <= ST_LIMIT;
        end
        S_SETUP: begin
          sub <= '0;
          if (total == '0) status <= ST_ZERO_DIV;
        end
        S_EST: begin
          ma <= 64'(g11);
          mb <= (sub == 2'd2) ? s : other;
          mgo <= 1'b1;
          est_mul <= 1'b1;
          if (sub == 2'd0) begin
            old0 <= pi0; old1 <= pi1; old2 <= pi2;
            acc <= '0;
          end
        end
        S_EST_WAIT: begin
          if (mdone && est_mul) begin
            est_mul <= 1'b0;
            dn <= (128'(cur_b) << FW) + mp;
            dd <= 128'({total, 1'b0});
            dgo <= 1'b1;
          end
          if (ddone) begin
            case (sub)
              2'd0: pi0 <= dq;
              2'd1: pi1 <= dq;
              default: pi2 <= dq;
            endcase
            sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
          end
        end
        // square each lane's change on the shared multiplier
        S_SQ: begin
          ma <= diff;
          mb <= diff;
          mgo <= 1'b1;
        end
        S_SQ_WAIT: if (mdone) begin
          acc <= acc + mp;
          sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        end
        S_CHECK: begin
          if (converged) status <= ST_CONVERGED;
          sub <= '0;
        end
        S_PROD: begin
          ma <= (sub == 2'd0) ? p00 : pi0;
          mb <= (sub == 2'd0) ? pi2 : pi1;
          mgo <= 1'b1;
        end
        S_PROD_WAIT: if (mdone) begin
          if (sub == 2'd0) begin
            prod_a <= mp;
            sub <= 2'd1;
          end else begin
            dd <= prod_a + mp;
            dn <= prod_a << FW;
            sub <= '0;
            if ((prod_a + mp) == '0) status <= ST_ZERO_DIV;
          end
        end
        S_SPLIT: dgo <= 1'b1;
        S_SPLIT_WAIT: if (ddone) begin
          s <= dq;
          rounds <= rounds + 8'd1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !busy) else $error("busy after result");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("cfg while busy");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule

// ===== rtl/tlhem_mul.sv =====
module tlhem_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [127:0] p
);
  import tlhem_pkg::*;

  logic [127:0] mcand;
  logic [63:0]  mplier;
  logic [6:0]   cnt;
  logic         run;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
        mcand <= {64'd0, a};
        mplier <= b;
        p <= '0;
      end else if (run) begin
        if (mplier[0]) p <= p + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/tlhem_div.sv =====
module tlhem_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] n,
  input  logic [127:0] d,
  output logic         done,
  output logic [63:0]  q
);
  import tlhem_pkg::*;

  logic [127:0] num;
  logic [127:0] rem;
  logic [127:0] quo;
  logic [127:0] den;
  logic [6:0]   cnt;
  logic         run;
  logic [128:0] sh;

  assign sh = {rem, num[127]};
  assign q = (quo[127:64] != 64'd0) ? {64{1'b1}} : quo[63:0];

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        num <= n;
        den <= d;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        num <= num << 1;
        if (sh >= {1'b0, den}) begin
          rem <= 128'(sh - {1'b0, den});
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= sh[127:0];
          quo <= {quo[126:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== tb/tlhem_checker.sv =====
module tlhem_checker
  import tlhem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  tlhem_in_t   item_in,
  input  logic        result_valid,
  input  tlhem_out_t  item_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          estimates_seen
);

  bit [7:0]   round_limit;
  bit [15:0]  stop_tol;
  tlhem_out_t estimates_due[$];

  // truncating quotient, saturated to 64 bits
  function automatic bit [63:0] quot64(bit [127:0] n, bit [127:0] d);
    bit [127:0] q;
    q = n / d;
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // haplotype frequencies for AB/ab share s of the double heterozygotes
  function automatic bit [2:0][63:0] hap_freqs(bit [8:0][63:0] g, bit [63:0] s,
                                                bit [127:0] dn);
    bit [63:0] one, other, b01, b10, b11;
    bit [2:0][63:0] f;
    one   = 64'd1 << FW;
    other = (s > one) ? 64'd0 : one - s;
    b01   = g[1] + 2 * g[2] + g[5];
    b10   = g[7] + 2 * g[6] + g[3];
    b11   = g[7] + 2 * g[8] + g[5];
    f[0]  = quot64((128'(b01) << FW) + 128'(g[4]) * 128'(other), dn);
    f[1]  = quot64((128'(b10) << FW) + 128'(g[4]) * 128'(other), dn);
    f[2]  = quot64((128'(b11) << FW) + 128'(g[4]) * 128'(s), dn);
    return f;
  endfunction

  function automatic tlhem_out_t em_estimate(tlhem_in_t t, bit [7:0] lim_reg,
                                             bit [15:0] tol);
    bit [8:0][63:0] g;
    bit [2:0][63:0] pi, prev;
    bit [63:0]  total, one, used, p00, s, d;
    bit [127:0] dn, a, den, change, thresh;
    int         rounds, limit;
    status_t    st;
    tlhem_out_t r;
    g = '{64'(t.count_22), 64'(t.count_21), 64'(t.count_20), 64'(t.count_12),
          64'(t.count_11), 64'(t.count_10), 64'(t.count_02), 64'(t.count_01),
          64'(t.count_00)};
    total = 0;
    for (int i = 0; i < 9; i++) total += g[i];
    one    = 64'd1 << FW;
    limit  = (lim_reg == 0) ? 1 : lim_reg;
    rounds = 0;
    st     = ST_LIMIT;
    pi     = '0;
    if (total == 0) begin
      st = ST_ZERO_DIV;
    end else begin
      dn     = 128'(2 * total);
      thresh = 128'(tol) << (2 * FW - 32);
      pi     = hap_freqs(g, one >> 1, dn);
      while (rounds < limit) begin
        used = pi[0] + pi[1] + pi[2];
        p00  = (used > one) ? 64'd0 : one - used;
        a    = 128'(p00) * 128'(pi[2]);
        den  = a + 128'(pi[0]) * 128'(pi[1]);
        if (den == 0) begin
          st = ST_ZERO_DIV;
          break;
        end
        s      = quot64(a << FW, den);
        prev   = pi;
        pi     = hap_freqs(g, s, dn);
        rounds++;
        change = 0;
        for (int i = 0; i < 3; i++) begin
          d = (pi[i] > prev[i]) ? pi[i] - prev[i] : prev[i] - pi[i];
          change += 128'(d) * 128'(d);
        end
        if (change <= thresh) begin
          st = ST_CONVERGED;
          break;
        end
      end
    end
    r.freq_01     = pi[0][31:0];
    r.freq_10     = pi[1][31:0];
    r.freq_11     = pi[2][31:0];
    r.status      = st;
    r.rounds_used = rounds[7:0];
    return r;
  endfunction

  assign pending = estimates_due.size();

  always @(posedge clk) begin
    tlhem_out_t want;
    if (rst) begin
      round_limit    <= 8'd100;
      stop_tol       <= 16'd429;
      estimates_due.delete();
      errors         <= 0;
      estimates_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_ITER:  round_limit <= cfg_data[7:0];
          REG_TOLERANCE: stop_tol    <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        estimates_due = {estimates_due, em_estimate(item_in, round_limit, stop_tol)};
      if (result_valid) begin
        estimates_seen <= estimates_seen + 1;
        if (estimates_due.size() == 0) begin
          $display("%0t: unexpected word %h", $time, item_out);
          errors <= errors + 1;
        end else begin
          want = estimates_due.pop_front();
          if (item_out.freq_01 !== want.freq_01 || item_out.freq_10 !== want.freq_10 ||
              item_out.freq_11 !== want.freq_11 || item_out.status !== want.status ||
              item_out.rounds_used !== want.rounds_used) begin
            $display("%0t: mismatch exp f01=%h f10=%h f11=%h st=%0d rnd=%0d", $time,
                     want.freq_01, want.freq_10, want.freq_11, want.status,
                     want.rounds_used);
            $display("%0t:          act f01=%h f10=%h f11=%h st=%0d rnd=%0d", $time,
                     item_out.freq_01, item_out.freq_10, item_out.freq_11,
                     item_out.status, item_out.rounds_used);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_two_locus_haplotype_em.sv =====
module tb_two_locus_haplotype_em;
  import tlhem_pkg::*;

  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int CMAX = (1 << CW) - 1;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  tlhem_in_t   item_in = '0;
  logic        result_valid;
  tlhem_out_t  item_out;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MAX_ITER;
  logic [15:0] cfg_data = '0;
  int          errors, pending, estimates_seen;
  int          cycles = 0;
  int          tables_sent = 0;
  int          settings_used = 1;
  bit          allow_gaps = 1;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  two_locus_haplotype_em i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .result_valid(result_valid), .item_out(item_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tlhem_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .result_valid(result_valid), .item_out(item_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .estimates_seen(estimates_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("two_locus_haplotype_em test failed");
      $finish;
    end
  end

  function automatic tlhem_in_t fill(int v00, int v01, int v02, int v10, int v11,
                                     int v12, int v20, int v21, int v22);
    tlhem_in_t t;
    t = '{CW'(v00), CW'(v01), CW'(v02), CW'(v10), CW'(v11), CW'(v12), CW'(v20),
          CW'(v21), CW'(v22)};
    return t;
  endfunction

  function automatic tlhem_in_t random_table();
    tlhem_in_t t;
    int kind, hi;
    t    = '0;
    kind = $urandom_range(0, 9);
    hi   = (kind < 4) ? CMAX : (kind < 8) ? 60 : 3;
    t = fill($urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
             $urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi),
             $urandom_range(0, hi), $urandom_range(0, hi), $urandom_range(0, hi));
    // thin out cells so sparse tables and zero divisors show up
    if (kind >= 6) t = t & {9{$urandom_range(0, 1) ? {CW{1'b1}} : {CW{1'b0}}}} &
                       tlhem_in_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), $urandom()});
    return t;
  endfunction

  task automatic send_table(tlhem_in_t t);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1;
    item_in <= t;
    do @(posedge clk); while (busy);
    tables_sent++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain, then program both registers
  task automatic set_regs(logic [15:0] lim_word, logic [15:0] tol);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_MAX_ITER, lim_word);
    write_reg(REG_TOLERANCE, tol);
    cfg_valid <= 0;
    settings_used++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed tables at reset settings
    send_table(fill(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_table(fill(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_table(fill(500, 0, 0, 0, 0, 0, 0, 0, 0));
    send_table(fill(0, 0, 0, 0, 0, 0, 0, 0, 77));
    send_table(fill(0, 0, 0, 0, CMAX, 0, 0, 0, 0));
    send_table(fill(0, 0, 9, 0, 0, 0, 0, 0, 0));
    send_table(fill(0, 0, 0, 0, 0, 0, 13, 0, 0));
    send_table(fill(1, 1, 1, 1, 1, 1, 1, 1, 1));
    send_table(fill(360, 480, 160, 240, 320, 100, 40, 50, 20));
    send_table(fill(25, 10, 1, 12, 40, 6, 2, 5, 9));
    send_table(fill('haaaaa, 'h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555, 'haaaaa,
                    'h55555, 'haaaaa));
    send_table(fill('h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555, 'haaaaa, 'h55555,
                    'haaaaa, 'h55555));
    send_table(fill(0, 0, 0, 0, 100, 0, 0, 0, 1));
    send_table(fill(1000, 0, 0, 0, 5, 0, 0, 0, 1000));
    send_table(fill(0, 1000, 0, 1000, 5, 0, 0, 0, 0));
    send_table(fill(0, 0, 0, 0, 1, 0, 0, 0, 0));

    // longest limit with zero tolerance; junk in the upper byte of the limit word
    set_regs(16'hc3ff, 16'd0);
    send_table(fill(50, 30, 5, 20, 60, 10, 4, 8, 3));
    send_table(random_table());

    // limit of zero acts as one, widest tolerance
    set_regs(16'h0000, 16'hffff);
    repeat (10) send_table(random_table());
    set_regs(16'h0001, 16'd0);
    repeat (10) send_table(random_table());

    for (int ph = 0; ph < 12; ph++) begin
      set_regs({8'($urandom), 8'($urandom_range(1, 4))}, 16'($urandom));
      if (ph == 11) allow_gaps = 0;
      repeat (115) send_table(random_table());
    end

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d genotype tables under %0d register settings, %0d estimates checked",
             tables_sent, settings_used, estimates_seen);
    if (errors == 0) begin
      $display("two_locus_haplotype_em test passed");
    end else begin
      $display("two_locus_haplotype_em test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlhem_pkg.sv
rtl/tlhem_mul.sv
rtl/tlhem_div.sv
rtl/two_locus_haplotype_em.sv
tb/tlhem_checker.sv
tb/tb_two_locus_haplotype_em.sv
